>>> sv/etol_pkg.sv
// ----------------------------------------------------------------------------
// etol_pkg
// Shared types and constants of the entry table ordinal lookup block.
// ----------------------------------------------------------------------------
package etol_pkg;

  // Bundle type byte that announces moveable entries.
  localparam logic [7:0] KindMoveable = 8'hFF;
  // Bundle type byte that announces a run of skipped ordinals.
  localparam logic [7:0] KindSkip     = 8'h00;

  // Position of the last byte of an entry, by entry kind.
  localparam logic [2:0] MoveableLastPos = 3'd5;
  localparam logic [2:0] FixedLastPos    = 3'd2;

  // Byte positions inside an entry that carry held fields.
  localparam logic [2:0] PosFlags       = 3'd0;
  localparam logic [2:0] PosFixedOffLo  = 3'd1;
  localparam logic [2:0] PosMovSegment  = 3'd3;
  localparam logic [2:0] PosMovOffLo    = 3'd4;

  localparam int unsigned ResultDataW = 32;
  localparam int unsigned ResultUserW = 3;

  typedef enum logic [3:0] {
    PH_COUNT = 4'b0001,
    PH_TYPE  = 4'b0010,
    PH_ENTRY = 4'b0100,
    PH_DROP  = 4'b1000
  } etol_phase_e;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_END_MARK  = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_TRUNCATED = 2'd3
  } etol_status_e;

  typedef struct packed {
    logic         found;
    etol_status_e status;
    logic [7:0]   segment_number;
    logic [15:0]  entry_offset;
    logic [7:0]   entry_flags;
  } etol_result_t;

  typedef struct packed {
    logic         valid;
    etol_result_t result;
  } etol_push_t;

endpackage

>>> sv/etol_parser.sv
// ----------------------------------------------------------------------------
// etol_parser
// Parse state of the entry table walk; one byte is consumed per transfer and
// a result is produced in the same step when the lookup outcome is known.
// ----------------------------------------------------------------------------
module etol_parser
  import etol_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        accept_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output etol_push_t  push_o
);

  etol_phase_e phase_q, phase_d;
  logic [7:0]  remaining_q, remaining_d;
  logic [7:0]  kind_q, kind_d;
  logic [2:0]  pos_q, pos_d;
  logic [15:0] ordinal_q, ordinal_d;
  logic [15:0] wanted_q;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  segment_q, segment_d;
  logic [7:0]  off_lo_q, off_lo_d;

  logic         emit;
  logic         fresh;
  logic         moveable;
  logic         entry_done;
  logic [7:0]   remaining_dec;
  etol_result_t res;

  assign moveable      = (kind_q == KindMoveable);
  assign entry_done    = moveable ? (pos_q >= MoveableLastPos) : (pos_q >= FixedLastPos);
  assign remaining_dec = remaining_q - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    ordinal_d   = ordinal_q;
    flags_d     = flags_q;
    segment_d   = segment_q;
    off_lo_d    = off_lo_q;
    emit        = 1'b0;
    fresh       = 1'b0;
    res         = '0;
    res.status  = ST_FOUND;

    unique case (phase_q)
      PH_COUNT: begin
        if (last_i) begin
          emit       = 1'b1;
          res.status = ST_EXHAUSTED;
        end else begin
          remaining_d = byte_i;
          phase_d     = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (remaining_q == 8'd0) begin
          emit       = 1'b1;
          res.status = ST_END_MARK;
        end else if (byte_i == KindSkip) begin
          kind_d    = byte_i;
          ordinal_d = ordinal_q + {8'd0, remaining_q};
          phase_d   = PH_COUNT;
          if (last_i) begin
            emit       = 1'b1;
            res.status = ST_EXHAUSTED;
          end
        end else begin
          kind_d  = byte_i;
          pos_d   = 3'd0;
          phase_d = PH_ENTRY;
          if (last_i) begin
            emit       = 1'b1;
            res.status = ST_TRUNCATED;
          end
        end
      end
      PH_ENTRY: begin
        if (pos_q == PosFlags) begin
          flags_d = byte_i;
        end
        if (moveable) begin
          if (pos_q == PosMovSegment) begin
            segment_d = byte_i;
          end else if (pos_q == PosMovOffLo) begin
            off_lo_d = byte_i;
          end
        end else begin
          segment_d = kind_q;
          if (pos_q == PosFixedOffLo) begin
            off_lo_d = byte_i;
          end
        end

        if (!entry_done) begin
          pos_d = pos_q + 3'd1;
          if (last_i) begin
            emit       = 1'b1;
            res.status = ST_TRUNCATED;
          end
        end else if (ordinal_q == wanted_q) begin
          // Fixed entries take their segment from the bundle type byte.
          emit               = 1'b1;
          res.found          = 1'b1;
          res.status         = ST_FOUND;
          res.segment_number = moveable ? segment_q : kind_q;
          res.entry_offset   = {byte_i, off_lo_q};
          res.entry_flags    = flags_q;
        end else begin
          ordinal_d   = ordinal_q + 16'd1;
          pos_d       = 3'd0;
          remaining_d = remaining_dec;
          if (remaining_dec == 8'd0) begin
            phase_d = PH_COUNT;
            if (last_i) begin
              emit       = 1'b1;
              res.status = ST_EXHAUSTED;
            end
          end else if (last_i) begin
            emit       = 1'b1;
            res.status = ST_TRUNCATED;
          end
        end
      end
      PH_DROP: begin
        fresh = last_i;
      end
      default: begin
        phase_d = PH_COUNT;
      end
    endcase

    // After a result the rest of the table is dropped; the last byte always
    // restarts the walk for the next table.
    if (emit) begin
      if (last_i) begin
        fresh = 1'b1;
      end else begin
        phase_d = PH_DROP;
      end
    end
    if (fresh) begin
      phase_d     = PH_COUNT;
      remaining_d = 8'd0;
      kind_d      = 8'd0;
      pos_d       = 3'd0;
      ordinal_d   = 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_COUNT;
      remaining_q <= 8'd0;
      kind_q      <= 8'd0;
      pos_q       <= 3'd0;
      ordinal_q   <= 16'd1;
      wanted_q    <= 16'd1;
    end else begin
      if (accept_i) begin
        phase_q     <= phase_d;
        remaining_q <= remaining_d;
        kind_q      <= kind_d;
        pos_q       <= pos_d;
        ordinal_q   <= ordinal_d;
      end
      if (cfg_we_i) begin
        wanted_q <= cfg_wdata_i;
      end
    end
  end

  // Held entry bytes are always written before they are read.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      flags_q   <= flags_d;
      segment_q <= segment_d;
      off_lo_q  <= off_lo_d;
    end
  end

  assign push_o.valid  = accept_i & emit;
  assign push_o.result = res;

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> phase_q == PH_COUNT && ordinal_q == 16'd1)
    else $error("last byte did not restart the table walk");

  a_result_then_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid && !last_i |=> phase_q == PH_DROP)
    else $error("result before the last byte did not enter the drop phase");

  a_miss_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid && !push_o.result.found |->
      push_o.result.segment_number == 8'd0 && push_o.result.entry_offset == 16'd0 &&
      push_o.result.entry_flags == 8'd0)
    else $error("miss result carries nonzero entry fields");

  a_no_result_in_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DROP |-> !push_o.valid)
    else $error("result produced while dropping bytes");
`endif

endmodule

>>> sv/etol_out_queue.sv
// ----------------------------------------------------------------------------
// etol_out_queue
// Two-entry result queue that decouples the byte input from the result
// output, so bytes keep flowing while a result waits to be taken.
// ----------------------------------------------------------------------------
module etol_out_queue
  import etol_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  etol_push_t             push_i,
  output logic                   space_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [ResultDataW-1:0] m_tdata_o,
  output logic [ResultUserW-1:0] m_tuser_o
);

  etol_result_t slot_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q, count_d;
  logic         pop;
  etol_result_t head;

  assign pop        = m_tvalid_o & m_tready_i;
  assign space_o    = (count_q != 2'd2);
  assign m_tvalid_o = (count_q != 2'd0);
  assign head       = slot_q[rd_ptr_q];

  assign m_tdata_o = {head.entry_flags, head.entry_offset, head.segment_number};
  assign m_tuser_o = {head.status, head.found};

  always_comb begin
    count_d = count_q;
    if (push_i.valid && !pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i.valid && pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i.valid) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.result;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> count_q != 2'd2)
    else $error("result pushed into a full queue");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  a_ptr_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with the fill count");
`endif

endmodule

>>> sv/entry_table_ordinal_lookup_core.sv
// ----------------------------------------------------------------------------
// entry_table_ordinal_lookup_core
// Walks an executable's entry table byte by byte and reports the entry of a
// configured ordinal, or why it was not found.
// ----------------------------------------------------------------------------
// The block takes one table byte per clock cycle on the input stream, with
// tlast on the table's final byte, and gives at most one result per table:
// the found entry, or end marker, table exhausted or truncated entry. The
// result is formed in the same cycle as the byte that decides it and enters a
// two-entry output queue; the input stalls only while that queue is full, so
// with the output side ready the sustained rate is one byte per cycle and a
// result appears in the cycle after its deciding byte. Bytes after a result are
// consumed and dropped up to tlast. The user writes wanted_ordinal over cfg_we_i
// only while the block is idle; the block itself does not enforce this.
module entry_table_ordinal_lookup_core
  import etol_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // wanted_ordinal
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] table_byte
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [7:0] segment_number, [23:8] entry_offset,
                                       // [31:24] entry_flags
  output logic [2:0]  m_axis_tuser_o   // [0] found, [2:1] lookup_status
);

  logic       accept;
  etol_push_t push;

  assign accept = s_axis_tvalid_i & s_axis_tready_o;

  etol_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .push_o      (push)
  );

  etol_out_queue u_out_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_o    (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

>>> tb/etol_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etol_lookup_checker
// Watches the table byte stream, the result stream and the ordinal register
// of the entry table lookup block. It walks each table on its own and
// compares every result transfer with the oldest lookup it expects.
// ----------------------------------------------------------------------------
module etol_lookup_checker
  import etol_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] table_byte
  input  logic        s_axis_tlast_i,   // last_byte
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // [7:0] segment_number, [23:8] entry_offset,
                                        // [31:24] entry_flags
  input  logic [2:0]  m_axis_tuser_i,   // [0] found, [2:1] lookup_status
  output int          mismatch_count_o,
  output int          pending_count_o
);

  etol_phase_e  walk_phase;
  logic [7:0]   left_in_bundle;
  logic [7:0]   kind_byte;
  logic [2:0]   entry_pos;
  logic [15:0]  ordinal_now;
  logic [15:0]  wanted_now;
  logic [7:0]   flags_hold;
  logic [7:0]   segment_hold;
  logic [7:0]   offlo_hold;

  etol_result_t pending_lookups[$];
  etol_result_t next_lookup;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count_o < 100) begin
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
    end
    mismatch_count_o++;
  endtask

  function automatic void restart_walk();
    walk_phase     = PH_COUNT;
    left_in_bundle = '0;
    kind_byte      = '0;
    entry_pos      = '0;
    ordinal_now    = 16'd1;
    flags_hold     = '0;
    segment_hold   = '0;
    offlo_hold     = '0;
  endfunction

  // Fills in a result; without tlast the rest of the table is dropped.
  function automatic void conclude(output etol_result_t res, input etol_status_e st,
                                   input logic last, input logic [7:0] seg,
                                   input logic [15:0] off, input logic [7:0] fl);
    res.found          = (st == ST_FOUND);
    res.status         = st;
    res.segment_number = seg;
    res.entry_offset   = off;
    res.entry_flags    = fl;
    if (last) begin
      restart_walk();
    end else begin
      walk_phase = PH_DROP;
    end
  endfunction

  function automatic bit predict_lookup(input logic [7:0] b, input logic last,
                                        output etol_result_t res);
    logic [2:0]  entry_last;
    logic [15:0] off;
    res = '0;
    case (walk_phase)
      PH_COUNT: begin
        // A bundle header needs both bytes, so even a zero count here is exhausted.
        if (last) begin
          conclude(res, ST_EXHAUSTED, 1'b1, '0, '0, '0);
          return 1'b1;
        end
        left_in_bundle = b;
        walk_phase = PH_TYPE;
        return 1'b0;
      end
      PH_TYPE: begin
        if (left_in_bundle == 8'd0) begin
          conclude(res, ST_END_MARK, last, '0, '0, '0);
          return 1'b1;
        end
        kind_byte = b;
        if (b == KindSkip) begin
          ordinal_now = ordinal_now + 16'(left_in_bundle);
          if (last) begin
            conclude(res, ST_EXHAUSTED, 1'b1, '0, '0, '0);
            return 1'b1;
          end
          walk_phase = PH_COUNT;
          return 1'b0;
        end
        if (last) begin
          conclude(res, ST_TRUNCATED, 1'b1, '0, '0, '0);
          return 1'b1;
        end
        entry_pos = '0;
        walk_phase = PH_ENTRY;
        return 1'b0;
      end
      PH_ENTRY: begin
        entry_last = (kind_byte == KindMoveable) ? MoveableLastPos : FixedLastPos;
        if (entry_pos == PosFlags) flags_hold = b;
        if (kind_byte == KindMoveable) begin
          if (entry_pos == PosMovSegment) segment_hold = b;
          else if (entry_pos == PosMovOffLo) offlo_hold = b;
        end else begin
          // Fixed entries take their segment from the bundle type byte.
          segment_hold = kind_byte;
          if (entry_pos == PosFixedOffLo) offlo_hold = b;
        end
        if (entry_pos != entry_last) begin
          entry_pos = entry_pos + 3'd1;
          if (last) begin
            conclude(res, ST_TRUNCATED, 1'b1, '0, '0, '0);
            return 1'b1;
          end
          return 1'b0;
        end
        off = {b, offlo_hold};
        if (ordinal_now == wanted_now) begin
          conclude(res, ST_FOUND, last, segment_hold, off, flags_hold);
          return 1'b1;
        end
        ordinal_now    = ordinal_now + 16'd1;
        entry_pos      = '0;
        left_in_bundle = left_in_bundle - 8'd1;
        if (left_in_bundle == 8'd0) begin
          walk_phase = PH_COUNT;
          if (last) begin
            conclude(res, ST_EXHAUSTED, 1'b1, '0, '0, '0);
            return 1'b1;
          end
        end else if (last) begin
          conclude(res, ST_TRUNCATED, 1'b1, '0, '0, '0);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (last) restart_walk();
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_result();
    etol_result_t want;
    if (pending_lookups.size() == 0) begin
      report_mismatch("result with no lookup pending", 16'(m_axis_tuser_i), '0);
      return;
    end
    want = pending_lookups.pop_front();
    if (m_axis_tuser_i[0] !== want.found)
      report_mismatch("found", 16'(m_axis_tuser_i[0]), 16'(want.found));
    if (m_axis_tuser_i[2:1] !== want.status)
      report_mismatch("lookup_status", 16'(m_axis_tuser_i[2:1]), 16'(want.status));
    if (m_axis_tdata_i[7:0] !== want.segment_number)
      report_mismatch("segment_number", 16'(m_axis_tdata_i[7:0]), 16'(want.segment_number));
    if (m_axis_tdata_i[23:8] !== want.entry_offset)
      report_mismatch("entry_offset", m_axis_tdata_i[23:8], want.entry_offset);
    if (m_axis_tdata_i[31:24] !== want.entry_flags)
      report_mismatch("entry_flags", 16'(m_axis_tdata_i[31:24]), 16'(want.entry_flags));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_now = 16'd1;
      restart_walk();
      pending_lookups.delete();
      mismatch_count_o = 0;
      pending_count_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (predict_lookup(s_axis_tdata_i, s_axis_tlast_i, next_lookup))
          pending_lookups.push_back(next_lookup);
      end
      if (cfg_we_i) wanted_now = cfg_wdata_i;
      pending_count_o <= pending_lookups.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the entry table ordinal lookup block.
// ----------------------------------------------------------------------------
// Directed tables hit every way a lookup can end, two long skip tables take
// the ordinal counter to FFFF and past it, random phases with a fresh wanted
// ordinal send well-formed, cut and padded tables mixed with noise. Both
// stream sides idle at random; the result side holds off to stall the input.
// ----------------------------------------------------------------------------
module tb;
  import etol_pkg::*;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [15:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tready_i = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  int          mismatches;
  int          lookups_pending;

  logic [7:0]  table_q[$];
  bit          tx_gapless = 1'b0;

  entry_table_ordinal_lookup_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  etol_lookup_checker lookup_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .s_axis_tlast_i   (s_axis_tlast_i),
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_i   (m_axis_tdata_o),
    .m_axis_tuser_i   (m_axis_tuser_o),
    .mismatch_count_o (mismatches),
    .pending_count_o  (lookups_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // Offers one byte after a random gap and returns at the edge of its transfer.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_gapless ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_table();
    if ($urandom_range(0, 5) == 0) tx_gapless = !tx_gapless;
    for (int i = 0; i < table_q.size(); i++) push_byte(table_q[i], i == table_q.size() - 1);
  endtask

  // Waits until every pending lookup has been answered, plus the block latency.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (lookups_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_wanted(input logic [15:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Skips enough ordinals to land on a high or wrapped ordinal, then one fixed entry.
  task automatic build_wrap(input int skip_total);
    int left;
    table_q.delete();
    left = skip_total;
    while (left > 0) begin
      table_q.push_back(8'(left > 255 ? 255 : left));
      table_q.push_back(KindSkip);
      left -= (left > 255) ? 255 : left;
    end
    table_q.push_back(8'd1);
    table_q.push_back(8'($urandom_range(1, 254)));
    repeat (3) table_q.push_back(8'($urandom));
    table_q.push_back(8'h00);
    table_q.push_back(8'h00);
  endtask

  task automatic build_wellformed();
    int count;
    int form;
    int cut;
    logic [7:0] kind;
    table_q.delete();
    repeat ($urandom_range(0, 4)) begin
      form = $urandom_range(0, 2);
      if (form == 0) begin
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 4);
        table_q.push_back(8'(count));
        table_q.push_back(KindSkip);
      end else begin
        count = $urandom_range(1, 4);
        kind  = (form == 1) ? KindMoveable : 8'($urandom_range(1, 254));
        table_q.push_back(8'(count));
        table_q.push_back(kind);
        repeat (count * ((form == 1) ? 6 : 3)) table_q.push_back(8'($urandom));
      end
    end
    table_q.push_back(8'h00);
    table_q.push_back(8'($urandom));
    // Some tables are cut short, some carry bytes past the end marker.
    case ($urandom_range(0, 9))
      0, 1: begin
        cut = $urandom_range(1, table_q.size());
        while (table_q.size() > cut) void'(table_q.pop_back());
      end
      2: repeat ($urandom_range(1, 5)) table_q.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  task automatic build_noise();
    table_q.delete();
    repeat ($urandom_range(1, 12)) table_q.push_back(8'($urandom));
  endtask

  initial begin : result_sink
    int hold;
    int taken;
    bit rx_gapless;
    taken      = 0;
    rx_gapless = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (taken == 25 || taken == 40) hold = 1000;
      else hold = rx_gapless ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 19) == 0) rx_gapless = !rx_gapless;
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      taken++;
    end
  end

  initial begin : stimulus
    int random_sent;
    int phase_goal;
    int phase_sent;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Wanted ordinal is still at its reset value of one here.
    table_q = '{8'h00};                                   send_table();
    table_q = '{8'h05};                                   send_table();
    table_q = '{8'h00, 8'h00};                            send_table();
    table_q = '{8'h00, 8'h37, 8'hAA, 8'hBB};              send_table();
    table_q = '{8'h02, 8'h00};                            send_table();
    table_q = '{8'h01, 8'h03};                            send_table();
    table_q = '{8'h01, 8'hFF, 8'h12, 8'h34};              send_table();
    table_q = '{8'h01, 8'hFE, 8'hA5, 8'h34, 8'h12};       send_table();
    table_q = '{8'h01, 8'hFF, 8'h5A, 8'hCD, 8'h3F, 8'h09, 8'h78, 8'h56,
                8'h00, 8'h00};                            send_table();
    table_q = '{8'h01, 8'h00, 8'h02, 8'h05, 8'h01, 8'h02, 8'h03,
                8'h04, 8'h05, 8'h06};                     send_table();
    table_q = '{8'h01, 8'h00, 8'h03, 8'h01, 8'h11, 8'h22, 8'h33};
    send_table();
    table_q = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_table();

    // The ordinal counter wraps, so both extremes of the register can match.
    write_wanted(16'h0000);
    build_wrap(65535);
    send_table();
    write_wanted(16'hFFFF);
    build_wrap(65534);
    send_table();

    // The directed and wrap tables above already carry about 1100 bytes.
    random_sent = 0;
    while (random_sent < 700) begin
      write_wanted(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12)));
      phase_goal = $urandom_range(80, 250);
      phase_sent = 0;
      while (phase_sent < phase_goal) begin
        if ($urandom_range(0, 4) == 0) build_noise();
        else build_wellformed();
        send_table();
        phase_sent += table_q.size();
      end
      random_sent += phase_sent;
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
